FILE: src/rrsas_pkg.sv
// Shared types, register indexes and sizing constants for the round-robin scheduler.
package rrsas_pkg;

   // Default number of task slots
   localparam int unsigned MAX_TASKS_DEF = 16;

   // Field widths
   localparam int unsigned TIME_W   = 32;
   localparam int unsigned SLICE_W  = 16;
   localparam int unsigned COUNT_W  = 5;
   localparam int unsigned OUT_TASK_W = 4;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 16;

   // Reset value of the slice length
   localparam logic [SLICE_W-1:0] SLICE_RESET = SLICE_W'(10);

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SCHED_ENABLE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SLICE_MS     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TASK_COUNT   = 2'd2;

   // Request actions
   localparam logic ACT_TICK  = 1'b0;
   localparam logic ACT_SLEEP = 1'b1;

   typedef struct packed {
      logic              action;
      logic [TIME_W-1:0] now_ms;
      logic [TIME_W-1:0] sleep_ms;
   } req_type;

   typedef struct packed {
      logic                  switched;
      logic                  had_previous;
      logic [OUT_TASK_W-1:0] prev_task;
      logic [OUT_TASK_W-1:0] next_task;
      logic                  first_run;
      logic                  none_ready;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_CHECK,
      ST_MOD,
      ST_SCAN,
      ST_COMMIT,
      ST_OUT
   } state_type;

endpackage

FILE: src/round_robin_sleep_aware_scheduler.sv
// Top level: sleep-aware round-robin time-slice task picker.
//
// Each request carries the current millisecond time and either a tick or a
// sleep for the running task; each request yields exactly one response.
// The block works on one request at a time and holds req_stall high until it
// is back in idle. A request passes through the read and check states; when no
// switch is needed it goes straight to the output state, and when it switches
// it first runs the repeated-subtract unit that wraps the round-robin start
// index into the task count, then the scan, which reads one deadline per cycle
// from the deadline memory's single read port, then the commit state. The
// response register can then wait on rsp_stall.
// Deadlines and slice starts live in two small memories with per-entry valid
// bits, so reset needs no clearing pass. Configuration (sched_enable,
// slice_ms, task_count at indexes 0 to 2) must be written only while the
// block is idle.
module round_robin_sleep_aware_scheduler
   import rrsas_pkg::*;
#(
   parameter int unsigned MAX_TASKS = MAX_TASKS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   // response channel
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   // configuration port
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int unsigned TIDX_W = $clog2(MAX_TASKS);
   localparam int unsigned CNT_W  = $clog2(MAX_TASKS + 1);
   localparam int unsigned CMP_W  = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
   localparam int unsigned EXT_W  = (TIDX_W > OUT_TASK_W) ? TIDX_W : OUT_TASK_W;

   // Control and configuration registers
   state_type             state_ff, state_in;
   logic                  enable_ff, enable_in;
   logic [SLICE_W-1:0]    slice_ms_ff, slice_ms_in;
   logic [COUNT_W-1:0]    task_count_ff, task_count_in;
   logic [TIDX_W-1:0]     cur_task_ff, cur_task_in;
   logic                  cur_valid_ff, cur_valid_in;
   logic [MAX_TASKS-1:0]  started_ff, started_in;
   logic [MAX_TASKS-1:0]  wake_vld_ff, wake_vld_in;
   logic [MAX_TASKS-1:0]  slice_vld_ff, slice_vld_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   // Payload registers
   req_type               item_ff, item_in;
   rsp_type               res_ff, res_in;
   rsp_type               rsp_ff, rsp_in;
   logic [CNT_W-1:0]      mod_ff, mod_in;
   logic [TIDX_W-1:0]     cand_ff, cand_in;
   logic [CNT_W-1:0]      left_ff, left_in;
   logic                  pend_ff, pend_in;
   logic [TIDX_W-1:0]     pend_cand_ff, pend_cand_in;
   logic [TIDX_W-1:0]     nxt_ff, nxt_in;

   // Memories
   logic [TIME_W-1:0]     wake_mem [MAX_TASKS];
   logic [TIME_W-1:0]     slice_mem [MAX_TASKS];
   logic [TIME_W-1:0]     wake_rd_ff;
   logic [TIME_W-1:0]     slice_rd_ff;
   logic                  wake_rd_vld_ff;
   logic                  slice_rd_vld_ff;
   logic [TIDX_W-1:0]     rd_addr;
   logic                  wake_we;
   logic [TIDX_W-1:0]     wake_waddr;
   logic [TIME_W-1:0]     wake_wdata;
   logic                  slice_we;

   // Derived values
   logic [CMP_W-1:0]      count_ext;
   logic [CNT_W-1:0]      eff_count;
   logic [TIME_W-1:0]     wake_val;
   logic [TIME_W-1:0]     slice_val;
   logic [TIME_W-1:0]     elapsed;
   logic                  expired;
   logic                  cur_asleep;
   logic                  cand_awake;
   logic                  need;
   logic [TIDX_W-1:0]     cand_next;
   logic [EXT_W-1:0]      cur_ext;
   logic [EXT_W-1:0]      pend_ext;

   // Clamp the task count to the number of slots
   assign count_ext = CMP_W'(task_count_ff);
   assign eff_count = (count_ext > CMP_W'(MAX_TASKS)) ? CNT_W'(MAX_TASKS)
                                                      : CNT_W'(count_ext);

   // Entries never written read as zero
   assign wake_val  = wake_rd_vld_ff  ? wake_rd_ff  : '0;
   assign slice_val = slice_rd_vld_ff ? slice_rd_ff : '0;

   // Slice and sleep tests against the latched time
   assign elapsed    = item_ff.now_ms - slice_val;
   assign expired    = elapsed > TIME_W'(slice_ms_ff);
   assign cur_asleep = wake_val >= item_ff.now_ms;
   assign cand_awake = wake_val < item_ff.now_ms;
   assign need       = !cur_valid_ff || expired || cur_asleep;

   // Cyclic successor of the issued candidate
   assign cand_next = ((CNT_W'(cand_ff) + CNT_W'(1)) == eff_count) ? '0
                                                                    : cand_ff + TIDX_W'(1);

   assign cur_ext  = EXT_W'(cur_task_ff);
   assign pend_ext = EXT_W'(pend_cand_ff);

   // Memory port control
   assign rd_addr    = (state_ff == ST_SCAN) ? cand_ff : cur_task_ff;
   assign wake_we    = (state_ff == ST_IDLE) && req_valid && (req_data.action == ACT_SLEEP)
                       && cur_valid_ff;
   assign wake_waddr = cur_task_ff;
   assign wake_wdata = req_data.now_ms + req_data.sleep_ms;
   assign slice_we   = (state_ff == ST_COMMIT);

   // Deadline memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wake_we) begin
         wake_mem[wake_waddr] <= wake_wdata;
      end
      wake_rd_ff     <= wake_mem[rd_addr];
      wake_rd_vld_ff <= wake_vld_ff[rd_addr];
   end

   // Slice start memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (slice_we) begin
         slice_mem[nxt_ff] <= item_ff.now_ms;
      end
      slice_rd_ff     <= slice_mem[rd_addr];
      slice_rd_vld_ff <= slice_vld_ff[rd_addr];
   end

   // Next state and datapath
   always_comb begin
      state_in      = state_ff;
      enable_in     = enable_ff;
      slice_ms_in   = slice_ms_ff;
      task_count_in = task_count_ff;
      cur_task_in   = cur_task_ff;
      cur_valid_in  = cur_valid_ff;
      started_in    = started_ff;
      wake_vld_in   = wake_vld_ff;
      slice_vld_in  = slice_vld_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      item_in       = item_ff;
      res_in        = res_ff;
      rsp_in        = rsp_ff;
      mod_in        = mod_ff;
      cand_in       = cand_ff;
      left_in       = left_ff;
      pend_in       = 1'b0;
      pend_cand_in  = pend_cand_ff;
      nxt_in        = nxt_ff;

      // Configuration writes
      if (csr_we) begin
         unique case (csr_index)
            CSR_SCHED_ENABLE: enable_in     = csr_wdata[0];
            CSR_SLICE_MS:     slice_ms_in   = csr_wdata[SLICE_W-1:0];
            CSR_TASK_COUNT:   task_count_in = csr_wdata[COUNT_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            // Take a request; a sleep stores the running task's deadline
            if (req_valid) begin
               item_in = req_data;
               if (wake_we) begin
                  wake_vld_in[wake_waddr] = 1'b1;
               end
               state_in = ST_READ;
            end
         end

         ST_READ: begin
            // Read the running task's deadline and slice start
            state_in = ST_CHECK;
         end

         ST_CHECK: begin
            // Decide whether to switch; capture previous-task fields
            res_in.switched     = 1'b0;
            res_in.had_previous = cur_valid_ff;
            res_in.prev_task    = cur_valid_ff ? cur_ext[OUT_TASK_W-1:0] : '0;
            res_in.next_task    = '0;
            res_in.first_run    = 1'b0;
            res_in.none_ready   = 1'b0;
            if (enable_ff && (eff_count != '0) && need) begin
               mod_in   = cur_valid_ff ? (CNT_W'(cur_task_ff) + CNT_W'(1)) : '0;
               state_in = ST_MOD;
            end else begin
               state_in = ST_OUT;
            end
         end

         ST_MOD: begin
            // Wrap the start index into the task count, one subtract per cycle
            if (mod_ff >= eff_count) begin
               mod_in = mod_ff - eff_count;
            end else begin
               cand_in  = mod_ff[TIDX_W-1:0];
               left_in  = eff_count;
               state_in = ST_SCAN;
            end
         end

         ST_SCAN: begin
            // Issue one candidate read and test the previous one each cycle
            if (left_ff != '0) begin
               pend_in      = 1'b1;
               pend_cand_in = cand_ff;
               cand_in      = cand_next;
               left_in      = left_ff - CNT_W'(1);
            end
            if (pend_ff && cand_awake) begin
               pend_in           = 1'b0;
               nxt_in            = pend_cand_ff;
               res_in.next_task  = pend_ext[OUT_TASK_W-1:0];
               res_in.none_ready = 1'b0;
               state_in          = ST_COMMIT;
            end else if (left_ff == '0) begin
               pend_in           = 1'b0;
               nxt_in            = '0;
               res_in.next_task  = '0;
               res_in.none_ready = 1'b1;
               state_in          = ST_COMMIT;
            end
         end

         ST_COMMIT: begin
            // Start the chosen task: clear its deadline, stamp its slice
            res_in.switched       = 1'b1;
            res_in.first_run      = !started_ff[nxt_ff];
            started_in[nxt_ff]    = 1'b1;
            wake_vld_in[nxt_ff]   = 1'b0;
            slice_vld_in[nxt_ff]  = 1'b1;
            cur_task_in           = nxt_ff;
            cur_valid_in          = 1'b1;
            state_in              = ST_OUT;
         end

         ST_OUT: begin
            // Hand the result to the response register once it is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Control and configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff     <= 1'b0;
         slice_ms_ff   <= SLICE_RESET;
         task_count_ff <= '0;
         cur_task_ff   <= '0;
         cur_valid_ff  <= 1'b0;
         started_ff    <= '0;
         wake_vld_ff   <= '0;
         slice_vld_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
         pend_ff       <= 1'b0;
      end else begin
         enable_ff     <= enable_in;
         slice_ms_ff   <= slice_ms_in;
         task_count_ff <= task_count_in;
         cur_task_ff   <= cur_task_in;
         cur_valid_ff  <= cur_valid_in;
         started_ff    <= started_in;
         wake_vld_ff   <= wake_vld_in;
         slice_vld_ff  <= slice_vld_in;
         rsp_valid_ff  <= rsp_valid_in;
         pend_ff       <= pend_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      item_ff      <= item_in;
      res_ff       <= res_in;
      rsp_ff       <= rsp_in;
      mod_ff       <= mod_in;
      cand_ff      <= cand_in;
      left_ff      <= left_in;
      pend_cand_ff <= pend_cand_in;
      nxt_ff       <= nxt_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for the sleep-aware round-robin scheduler: directed cases, random traffic, scoreboard.
module tb_top;
   import rrsas_pkg::*;

   localparam int unsigned MAX_TASKS    = MAX_TASKS_DEF;
   localparam int unsigned DRAIN_CYCLES = 64;
   localparam int unsigned PRINT_LIMIT  = 50;
   // index past the last register, written to show it is ignored
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_type               req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // scheduler state as the block should hold it
   logic [TIME_W-1:0]     wake_at [MAX_TASKS];
   logic [TIME_W-1:0]     slice_begin [MAX_TASKS];
   logic                  ran_before [MAX_TASKS];
   logic [3:0]            run_task = '0;
   logic                  run_valid = 1'b0;
   logic                  cfg_enable = 1'b0;
   logic [SLICE_W-1:0]    cfg_slice = SLICE_RESET;
   logic [COUNT_W-1:0]    cfg_count = '0;

   rsp_type               expected_picks [$];
   rsp_type               pick_want;
   logic [TIME_W-1:0]     clock_ms = 32'd1000;
   int                    sender_idle_pct = 0;
   int                    rsp_stall_pct = 0;
   int                    error_count = 0;
   int                    items_sent = 0;
   int                    picks_checked = 0;
   int                    switch_count = 0;
   int                    first_run_count = 0;
   int                    fallback_count = 0;
   int                    phase_count = 0;

   round_robin_sleep_aware_scheduler dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // clear the task tables to their reset contents
   initial begin
      for (int i = 0; i < MAX_TASKS; i++) begin
         wake_at[i]     = '0;
         slice_begin[i] = '0;
         ran_before[i]  = 1'b0;
      end
   end

   // work out the decision for one request and advance the task tables
   function automatic rsp_type predict_pick(input req_type item);
      rsp_type           pick;
      int unsigned       live;
      int unsigned       cur;
      int unsigned       first_cand;
      int unsigned       cand;
      logic [TIME_W-1:0] elapsed;
      bit                need;
      bit                found;
      pick = '0;
      live = (cfg_count > MAX_TASKS) ? MAX_TASKS : cfg_count;
      cur  = run_task;
      // store the deadline of the running task; ignore when none runs
      if (item.action == ACT_SLEEP && run_valid)
         wake_at[cur] = item.now_ms + item.sleep_ms;
      elapsed = item.now_ms - slice_begin[cur];
      need = !run_valid || (elapsed > cfg_slice) || (wake_at[cur] >= item.now_ms);
      pick.had_previous = run_valid;
      pick.prev_task    = run_valid ? cur[OUT_TASK_W-1:0] : '0;
      if (cfg_enable && live > 0 && need) begin
         // scan cyclically after the running task, running task last
         first_cand = run_valid ? (cur + 1) % live : 0;
         found = 1'b0;
         cand  = 0;
         for (int unsigned k = 0; k < live && !found; k++) begin
            cand  = (first_cand + k) % live;
            found = (wake_at[cand] < item.now_ms);
         end
         // fall back to task 0 when everyone sleeps
         if (!found) begin
            cand = 0;
            pick.none_ready = 1'b1;
         end
         pick.switched   = 1'b1;
         pick.next_task  = cand[OUT_TASK_W-1:0];
         pick.first_run  = !ran_before[cand];
         wake_at[cand]     = '0;
         ran_before[cand]  = 1'b1;
         slice_begin[cand] = item.now_ms;
         run_task  = cand[3:0];
         run_valid = 1'b1;
      end
      return pick;
   endfunction

   task automatic report_mismatch(input string msg);
      if (error_count < PRINT_LIMIT)
         $display("ERROR at %0t ns: %s", $time, msg);
      error_count++;
   endtask

   task automatic check_field(input string name, input logic [3:0] got, input logic [3:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got %0h, expected %0h", name, got, want));
   endtask

   // compare each response transfer with the oldest pending decision
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_picks.size() == 0) begin
            report_mismatch("response transfer with no decision pending");
         end else begin
            pick_want = expected_picks.pop_front();
            check_field("switched", rsp_data.switched, pick_want.switched);
            check_field("had_previous", rsp_data.had_previous, pick_want.had_previous);
            check_field("prev_task", rsp_data.prev_task, pick_want.prev_task);
            check_field("next_task", rsp_data.next_task, pick_want.next_task);
            check_field("first_run", rsp_data.first_run, pick_want.first_run);
            check_field("none_ready", rsp_data.none_ready, pick_want.none_ready);
            picks_checked++;
            switch_count    += pick_want.switched;
            first_run_count += pick_want.first_run;
            fallback_count  += pick_want.none_ready;
         end
      end
   end

   // receiver back-pressure
   always @(posedge clock)
      rsp_stall <= ($urandom_range(99) < rsp_stall_pct);

   function automatic req_type make_req(input logic act, input logic [TIME_W-1:0] now,
                                        input logic [TIME_W-1:0] dur);
      req_type item;
      item.action   = act;
      item.now_ms   = now;
      item.sleep_ms = dur;
      return item;
   endfunction

   // offer one request, hold it until the transfer, then record its decision
   task automatic send_item(input req_type item);
      if (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < sender_idle_pct);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      expected_picks.push_back(predict_pick(item));
      items_sent++;
   endtask

   // drop valid and wait until the block has answered everything
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_picks.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         CSR_SCHED_ENABLE: cfg_enable = data[0];
         CSR_SLICE_MS:     cfg_slice  = data[SLICE_W-1:0];
         CSR_TASK_COUNT:   cfg_count  = data[COUNT_W-1:0];
         default:          ;
      endcase
   endtask

   // write all registers while idle; unused upper bits carry noise
   task automatic set_config(input bit en, input int unsigned slice, input int unsigned count);
      logic [CSR_DATA_W-1:0] en_w;
      logic [CSR_DATA_W-1:0] count_w;
      en_w    = CSR_DATA_W'($urandom);
      en_w[0] = en;
      count_w = CSR_DATA_W'($urandom);
      count_w[COUNT_W-1:0] = count[COUNT_W-1:0];
      wait_idle();
      write_reg(CSR_SCHED_ENABLE, en_w);
      write_reg(CSR_SLICE_MS, slice[SLICE_W-1:0]);
      write_reg(CSR_TASK_COUNT, count_w);
      write_reg(CSR_UNUSED, CSR_DATA_W'($urandom));
      csr_we <= 1'b0;
      @(posedge clock);
      phase_count++;
   endtask

   // reset settings: disabled, no tasks, sleep with nothing running
   task automatic test_after_reset();
      send_item(make_req(ACT_TICK, 32'd0, 32'd0));
      send_item(make_req(ACT_SLEEP, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
   endtask

   // walk the round-robin order through expiry, sleeps and the all-asleep fallback
   task automatic test_round_robin_order();
      set_config(1'b1, 10, 4);
      send_item(make_req(ACT_TICK, 32'd0, 32'd0));
      send_item(make_req(ACT_TICK, 32'd5, 32'd0));
      send_item(make_req(ACT_TICK, 32'd20, 32'd0));
      send_item(make_req(ACT_SLEEP, 32'd21, 32'd100));
      send_item(make_req(ACT_SLEEP, 32'd22, 32'd0));
      send_item(make_req(ACT_SLEEP, 32'd23, 32'd1000));
      send_item(make_req(ACT_SLEEP, 32'd24, 32'd1000));
      send_item(make_req(ACT_SLEEP, 32'd25, 32'd1000));
      send_item(make_req(ACT_TICK, 32'd40, 32'd0));
   endtask

   // disabled sleep, clamped count, zero and full slice, shrunk and empty task list
   task automatic test_config_corners();
      set_config(1'b0, 10, 4);
      send_item(make_req(ACT_SLEEP, 32'd50, 32'd500));
      send_item(make_req(ACT_TICK, 32'd60, 32'd0));
      set_config(1'b1, 0, 31);
      send_item(make_req(ACT_TICK, 32'd61, 32'd0));
      send_item(make_req(ACT_TICK, 32'd61, 32'd0));
      send_item(make_req(ACT_TICK, 32'd62, 32'd0));
      set_config(1'b1, 65535, 3);
      send_item(make_req(ACT_TICK, 32'd63, 32'd0));
      send_item(make_req(ACT_SLEEP, 32'd70, 32'd5));
      set_config(1'b1, 10, 0);
      send_item(make_req(ACT_TICK, 32'd80, 32'd0));
   endtask

   // deadline and slice arithmetic across the 32-bit wrap
   task automatic test_time_wrap();
      set_config(1'b1, 10, 16);
      send_item(make_req(ACT_SLEEP, 32'hFFFF_FFF0, 32'd32));
      send_item(make_req(ACT_TICK, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
      send_item(make_req(ACT_TICK, 32'd5, 32'd0));
      send_item(make_req(ACT_TICK, 32'd0, 32'hFFFF_FFFF));
   endtask

   // mostly well-formed advancing time with random sleeps, some random noise
   task automatic test_random_traffic(input int send_idle, input int recv_stall, input bit en,
                                      input int unsigned slice, input int unsigned count,
                                      input int n);
      req_type     item;
      int unsigned span;
      set_config(en, slice, count);
      sender_idle_pct = send_idle;
      rsp_stall_pct   = recv_stall;
      span = cfg_slice + cfg_slice / 2 + 3;
      repeat (n) begin
         item.action = ($urandom_range(99) < 40) ? ACT_SLEEP : ACT_TICK;
         if ($urandom_range(99) < 3) begin
            item.now_ms   = $urandom;
            item.sleep_ms = $urandom;
         end else begin
            clock_ms      = clock_ms + $urandom_range(span);
            item.now_ms   = clock_ms;
            item.sleep_ms = $urandom_range(4 * span);
         end
         send_item(item);
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_after_reset();
      test_round_robin_order();
      test_config_corners();
      test_time_wrap();
      test_random_traffic(0, 0, 1'b1, 10, 16, 185);
      test_random_traffic(86, 0, 1'b1, 0, 5, 185);
      test_random_traffic(0, 86, 1'b1, 65535, 31, 185);
      test_random_traffic(16, 16, 1'b1, $urandom_range(40, 1), 1, 185);
      test_random_traffic(0, 0, 1'b1, $urandom_range(30, 2), $urandom_range(16, 2), 185);
      test_random_traffic(86, 0, 1'b0, 10, 8, 185);
      test_random_traffic(16, 16, 1'b1, $urandom_range(20), $urandom_range(31), 185);
      clock_ms = 32'hFFFF_FF00;
      test_random_traffic(0, 86, 1'b1, 3, 2, 185);
      wait_idle();
      if (expected_picks.size() != 0)
         report_mismatch("decisions left without a response");
      $display("Summary: %0d requests in %0d register settings, %0d responses checked",
               items_sent, phase_count, picks_checked);
      $display("Summary: %0d switches, %0d first runs, %0d all-asleep fallbacks, %0d errors",
               switch_count, first_run_count, fallback_count, error_count);
      if (error_count == 0)
         $display("tb_top: PASS");
      else
         $display("tb_top: FAIL");
      $finish;
   end

   // end a hung run
   initial begin
      #10_000_000;
      $display("tb_top: FAIL");
      $finish;
   end

endmodule
